>>> sv/tans_pkg.sv
// Shared types, codes and sizes for the texture address nearest sampler.
package tans_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int SIZE_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] MODE_WRAP   = 2'd0;
    localparam logic [1:0] MODE_CLAMP  = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;

    typedef struct packed {
        logic              func;
        logic [7:0]        load_x;
        logic [7:0]        load_y;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic [1:0]        mode_u;
        logic [1:0]        mode_v;
    } req_t;

    typedef struct packed {
        logic [7:0] sample_red;
        logic [7:0] sample_green;
        logic [7:0] sample_blue;
        logic [7:0] sample_alpha;
        logic [7:0] texel_x;
        logic [7:0] texel_y;
    } result_t;

    typedef struct packed {
        logic              is_sample;
        logic [SIZE_W-1:0] col;
        logic [SIZE_W-1:0] row;
        logic [31:0]       texel;
    } op_t;

endpackage

>>> sv/texture_address_nearest_sampler_top.sv
// Top level of the texture address nearest sampler.
//
// channel  direction  handshake             payload
// req      in         push / full           tans_pkg::req_t
// result   out        empty / pop           tans_pkg::result_t
// cfg      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle while full is low; a sample result passes two front stages, the mid
// queue, one registered store read and the result queue before it can be popped.
// A load takes the single store port; a load and a sample never share it.
// Reset clears control state and sets both image sizes to 1; texels are undefined until loaded.
// full rises when the mid queue plus the front stages hold eight requests; a stalled
// result queue stops store reads, then the mid queue fills.
module texture_address_nearest_sampler_top #(
    parameter int MAX_WIDTH  = tans_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tans_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = tans_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  tans_pkg::req_t                 req,
    output logic                           empty,
    input  logic                           pop,
    output tans_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tans_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tans_pkg::SIZE_W-1:0]    cfg_data
);

    localparam int S_W    = tans_pkg::SIZE_W;
    localparam int OP_W   = $bits(tans_pkg::op_t);
    localparam int MCNT_W = $clog2(tans_pkg::MID_DEPTH + 1);

    logic [S_W-1:0]    width_reg;
    logic [S_W-1:0]    height_reg;
    logic [S_W-1:0]    size_w;
    logic [S_W-1:0]    size_h;
    logic              accept;
    logic              front_valid;
    tans_pkg::op_t     front_op;
    logic [1:0]        front_busy;
    logic              mid_empty;
    logic [MCNT_W-1:0] mid_count;
    logic [OP_W-1:0]   mid_data;
    logic              mid_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= S_W'(1);
            height_reg <= S_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tans_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                tans_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            size_w = S_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            size_w = S_W'(MAX_WIDTH);
        else
            size_w = width_reg;

        if (height_reg == '0)
            size_h = S_W'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            size_h = S_W'(MAX_HEIGHT);
        else
            size_h = height_reg;
    end

    assign full   = (32'(mid_count) + 32'(front_busy)) >= 32'(tans_pkg::MID_DEPTH);
    assign accept = push && !full;

    tans_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (req),
        .size_w   (size_w),
        .size_h   (size_h),
        .op_valid (front_valid),
        .op       (front_op),
        .busy     (front_busy)
    );

    tans_fifo #(
        .WIDTH (OP_W),
        .DEPTH (tans_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_op),
        .pop       (mid_take),
        .pop_data  (mid_data),
        .empty     (mid_empty),
        .count     (mid_count)
    );

    tans_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!mid_empty),
        .op       (tans_pkg::op_t'(mid_data)),
        .op_take  (mid_take),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

>>> sv/tans_fifo.sv
// Small register queue with occupancy count.
module tans_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

>>> sv/tans_front.sv
// Front end: coordinate addressing, scaling to texel indices and load classification.
module tans_front #(
    parameter int MAX_WIDTH  = tans_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tans_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = tans_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  tans_pkg::req_t              req,
    input  logic [tans_pkg::SIZE_W-1:0] size_w,
    input  logic [tans_pkg::SIZE_W-1:0] size_h,
    output logic                        op_valid,
    output tans_pkg::op_t               op,
    output logic [1:0]                  busy
);

    localparam int A_W   = FRAC_BITS + 1;
    localparam int P_W   = A_W + tans_pkg::SIZE_W;
    localparam int I_W   = P_W - FRAC_BITS;
    localparam int S_W   = tans_pkg::SIZE_W;
    localparam logic [A_W-1:0] FIX_ONE = A_W'(1) << FRAC_BITS;

    function automatic logic [A_W-1:0] address_coord(input logic [31:0] bits,
                                                     input logic [1:0]  mode);
        logic [30:0]    mag;
        logic [A_W-1:0] period;
        logic [A_W:0]   reflect;
        logic [A_W-1:0] res;
        mag     = bits[30:0];
        period  = bits[FRAC_BITS:0];
        reflect = {FIX_ONE, 1'b0} - {1'b0, period};
        case (mode)
            tans_pkg::MODE_CLAMP:
            begin
                if (bits[31])
                    res = '0;
                else if (32'(mag) > 32'(FIX_ONE))
                    res = FIX_ONE;
                else
                    res = mag[A_W-1:0];
            end
            tans_pkg::MODE_MIRROR:
            begin
                res = (period > FIX_ONE) ? reflect[A_W-1:0] : period;
            end
            default:
            begin
                res = {1'b0, bits[FRAC_BITS-1:0]};
            end
        endcase
        return res;
    endfunction

    function automatic logic [S_W-1:0] limit_index(input logic [P_W-1:0] prod,
                                                   input logic [S_W-1:0] size);
        logic [I_W-1:0] idx;
        logic [S_W-1:0] top;
        idx = prod[P_W-1:FRAC_BITS];
        top = size - 1'b1;
        return (idx > I_W'(top)) ? top : idx[S_W-1:0];
    endfunction

    logic           s1_valid_reg;
    logic           s1_sample_reg;
    logic           s1_keep_reg;
    logic [A_W-1:0] s1_au_reg;
    logic [A_W-1:0] s1_av_reg;
    logic [31:0]    s1_texel_reg;
    logic [7:0]     s1_lx_reg;
    logic [7:0]     s1_ly_reg;

    logic           s2_valid_reg;
    logic           s2_sample_reg;
    logic           s2_keep_reg;
    logic [P_W-1:0] s2_pu_reg;
    logic [P_W-1:0] s2_pv_reg;
    logic [31:0]    s2_texel_reg;
    logic [7:0]     s2_lx_reg;
    logic [7:0]     s2_ly_reg;

    logic           in_store;

    assign in_store = (32'(req.load_x) < 32'(MAX_WIDTH)) && (32'(req.load_y) < 32'(MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg <= (req.func == tans_pkg::FUNC_SAMPLE);
        s1_keep_reg   <= (req.func == tans_pkg::FUNC_SAMPLE) || in_store;
        s1_au_reg     <= address_coord(req.coord_u, req.mode_u);
        s1_av_reg     <= address_coord(req.coord_v, req.mode_v);
        s1_texel_reg  <= {req.alpha, req.blue, req.green, req.red};
        s1_lx_reg     <= req.load_x;
        s1_ly_reg     <= req.load_y;

        s2_sample_reg <= s1_sample_reg;
        s2_keep_reg   <= s1_keep_reg;
        s2_pu_reg     <= P_W'(s1_au_reg) * P_W'(size_w);
        s2_pv_reg     <= P_W'(s1_av_reg) * P_W'(size_h);
        s2_texel_reg  <= s1_texel_reg;
        s2_lx_reg     <= s1_lx_reg;
        s2_ly_reg     <= s1_ly_reg;
    end

    always_comb
    begin
        op.is_sample = s2_sample_reg;
        op.texel     = s2_texel_reg;
        if (s2_sample_reg)
        begin
            op.col = limit_index(s2_pu_reg, size_w);
            op.row = limit_index(s2_pv_reg, size_h);
        end
        else
        begin
            op.col = {1'b0, s2_lx_reg};
            op.row = {1'b0, s2_ly_reg};
        end
    end

    assign op_valid = s2_valid_reg && s2_keep_reg;
    assign busy     = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

>>> sv/tans_back.sv
// Back end: texel store access and result queue.
module tans_back #(
    parameter int MAX_WIDTH  = tans_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = tans_pkg::MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  tans_pkg::op_t     op,
    output logic              op_take,
    output tans_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCNT_W = $clog2(tans_pkg::OUT_DEPTH + 1);
    localparam int RES_W  = $bits(tans_pkg::result_t);

    logic [31:0]       store [DEPTH];
    logic [AW-1:0]     addr;
    logic              room;
    logic              do_write;
    logic              do_read;
    logic              rd_pend_reg;
    logic [31:0]       rd_data_reg;
    logic [7:0]        rd_col_reg;
    logic [7:0]        rd_row_reg;
    logic [OCNT_W-1:0] out_count;
    logic              out_pop;
    logic [RES_W-1:0]  out_data;
    tans_pkg::result_t res_in;

    assign addr     = AW'(32'(op.row) * 32'(MAX_WIDTH) + 32'(op.col));
    assign room     = (32'(out_count) + 32'(rd_pend_reg)) < 32'(tans_pkg::OUT_DEPTH);
    assign op_take  = op_valid && (!op.is_sample || room);
    assign do_write = op_take && !op.is_sample;
    assign do_read  = op_take && op.is_sample;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store[addr] <= op.texel;
        end
        else if (do_read)
        begin
            rd_data_reg <= store[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            rd_col_reg <= op.col[7:0];
            rd_row_reg <= op.row[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_pend_reg <= 1'b0;
        else
            rd_pend_reg <= do_read;
    end

    assign res_in.sample_red   = rd_data_reg[7:0];
    assign res_in.sample_green = rd_data_reg[15:8];
    assign res_in.sample_blue  = rd_data_reg[23:16];
    assign res_in.sample_alpha = rd_data_reg[31:24];
    assign res_in.texel_x      = rd_col_reg;
    assign res_in.texel_y      = rd_row_reg;

    assign out_pop = pop && !empty;

    tans_fifo #(
        .WIDTH (RES_W),
        .DEPTH (tans_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_pend_reg),
        .push_data (res_in),
        .pop       (out_pop),
        .pop_data  (out_data),
        .empty     (empty),
        .count     (out_count)
    );

    assign result = tans_pkg::result_t'(out_data);

endmodule

>>> dv/tb_sampler_pkg.sv
// Scoreboard for the texture sampler: texel store, image sizes and nearest-texel addressing.
`timescale 1ns / 100ps

package tb_sampler_pkg;
    import tans_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int STORE_DEPTH         = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int unsigned UNIT       = 1 << FRAC_BITS_DEF;

    class sampler_scoreboard;
        logic [31:0]       texel_mem [STORE_DEPTH];
        logic [SIZE_W-1:0] width_reg  = SIZE_W'(1);
        logic [SIZE_W-1:0] height_reg = SIZE_W'(1);
        result_t           expected_q [$];
        int                errors     = 0;

        function void set_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
            width_reg  = w;
            height_reg = h;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        static function int unsigned fold_coord(logic [31:0] c, logic [1:0] mode);
            int unsigned period;
            case (mode)
                MODE_CLAMP:
                begin
                    if (c[31])
                        return 0;
                    if (c[30:0] > UNIT)
                        return UNIT;
                    return c;
                end
                MODE_MIRROR:
                begin
                    period = c & (2 * UNIT - 1);
                    return (period > UNIT) ? 2 * UNIT - period : period;
                end
                default:
                    return c & (UNIT - 1);
            endcase
        endfunction

        static function logic [7:0] nearest_index(logic [31:0] c, logic [1:0] mode,
                                                   logic [SIZE_W-1:0] size_reg, int max_size);
            int unsigned size;
            int unsigned idx;
            if (size_reg == 0)
                size = 1;
            else if (size_reg > max_size)
                size = max_size;
            else
                size = size_reg;
            idx = (fold_coord(c, mode) * size) >> FRAC_BITS_DEF;
            if (idx > size - 1)
                idx = size - 1;
            return idx[7:0];
        endfunction

        function logic [7:0] column_of(logic [31:0] u, logic [1:0] mode);
            return nearest_index(u, mode, width_reg, MAX_WIDTH_DEF);
        endfunction

        function logic [7:0] row_of(logic [31:0] v, logic [1:0] mode);
            return nearest_index(v, mode, height_reg, MAX_HEIGHT_DEF);
        endfunction

        function void note_request(req_t r);
            result_t exp_res;
            if (r.func == FUNC_LOAD)
            begin
                texel_mem[{r.load_y, r.load_x}] = {r.alpha, r.blue, r.green, r.red};
                return;
            end
            exp_res.texel_x = column_of(r.coord_u, r.mode_u);
            exp_res.texel_y = row_of(r.coord_v, r.mode_v);
            {exp_res.sample_alpha, exp_res.sample_blue, exp_res.sample_green,
             exp_res.sample_red} = texel_mem[{exp_res.texel_y, exp_res.texel_x}];
            expected_q = {expected_q, exp_res};
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result %h with no sample waiting", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("sample_red", want.sample_red, got.sample_red);
            compare_field("sample_green", want.sample_green, got.sample_green);
            compare_field("sample_blue", want.sample_blue, got.sample_blue);
            compare_field("sample_alpha", want.sample_alpha, got.sample_alpha);
            compare_field("texel_x", want.texel_x, got.texel_x);
            compare_field("texel_y", want.texel_y, got.texel_y);
        endfunction
    endclass

endpackage

>>> dv/tb_top.sv
// Testbench top: drives loads and samples into the texture sampler and checks every result.
`timescale 1ns / 100ps

module tb_top;
    import tans_pkg::*;
    import tb_sampler_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int PHASES           = 9;
    localparam int CALM_PHASE       = 3;
    localparam int HOLD_PHASE       = 4;
    localparam int HOLD_CYCLES      = 200;
    localparam int SETTLE_CYCLES    = 24;

    localparam logic [SIZE_W-1:0] PHASE_W [PHASES] = '{256, 1, 0, 7, 256, 511, 16, 1, 3};
    localparam logic [SIZE_W-1:0] PHASE_H [PHASES] = '{1, 256, 511, 13, 256, 0, 16, 1, 200};

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    req_t                 req;
    logic                 empty;
    logic                 pop;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    sampler_scoreboard sb = new();
    bit                loaded [STORE_DEPTH];
    bit                calm;
    bit                hold_request;
    int                cycles;

    texture_address_nearest_sampler_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(result);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= calm || ($urandom_range(99) >= 26);
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(5 * UNIT) - 5 * UNIT / 2;
            2: return ($urandom_range(6) - 3) * UNIT + $urandom_range(2) - 1;
            default:
                case ($urandom_range(5))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return UNIT;
                    3: return 2 * UNIT;
                    4: return 2 * UNIT - 1;
                    default: return UNIT - 1;
                endcase
        endcase
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.func    = 1'($urandom_range(1));
        r.load_x  = 8'($urandom());
        r.load_y  = 8'($urandom());
        {r.alpha, r.blue, r.green, r.red} = $urandom();
        r.coord_u = rand_coord();
        r.coord_v = rand_coord();
        r.mode_u  = 2'($urandom_range(MODE_SPARE));
        r.mode_v  = 2'($urandom_range(MODE_SPARE));
        return r;
    endfunction

    task automatic send_req(input req_t r);
        while (!calm && $urandom_range(99) < 26)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req  <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic load_texel(input logic [7:0] x, input logic [7:0] y, input logic [31:0] word);
        req_t r;
        r        = rand_req();
        r.func   = FUNC_LOAD;
        r.load_x = x;
        r.load_y = y;
        {r.alpha, r.blue, r.green, r.red} = word;
        loaded[{y, x}] = 1'b1;
        send_req(r);
    endtask

    task automatic sample_at(input logic [31:0] u, input logic [31:0] v,
                             input logic [1:0] mu, input logic [1:0] mv);
        req_t       r;
        logic [7:0] x;
        logic [7:0] y;
        x = sb.column_of(u, mu);
        y = sb.row_of(v, mv);
        // load the selected texel first if it has never been written
        if (!loaded[{y, x}])
            load_texel(x, y, $urandom());
        r         = rand_req();
        r.func    = FUNC_SAMPLE;
        r.coord_u = u;
        r.coord_v = v;
        r.mode_u  = mu;
        r.mode_v  = mv;
        send_req(r);
    endtask

    task automatic random_item();
        req_t r;
        r = rand_req();
        if ($urandom_range(99) < 30)
            load_texel(r.load_x, r.load_y, $urandom());
        else
            sample_at(r.coord_u, r.coord_v, r.mode_u, r.mode_v);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_image(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_size(w, h);
    endtask

    task automatic run_directed();
        load_texel(8'd0, 8'd0, 32'h0000_0000);
        load_texel(8'd4, 8'd2, 32'hFFFF_FFFF);
        load_texel(8'd255, 8'd255, 32'h5A5A_A5A5);
        load_texel(8'd255, 8'd0, 32'hC33C_3CC3);
        sample_at(32'h0, 32'h0, MODE_WRAP, MODE_WRAP);
        sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, MODE_CLAMP, MODE_CLAMP);
        sample_at(32'h8000_0000, 32'hFFFF_FFFF, MODE_CLAMP, MODE_CLAMP);
        sample_at(UNIT, UNIT, MODE_CLAMP, MODE_CLAMP);
        sample_at(UNIT, UNIT, MODE_MIRROR, MODE_MIRROR);
        sample_at(2 * UNIT - 1, 32'hFFFF_FFFF, MODE_MIRROR, MODE_MIRROR);
        sample_at(2 * UNIT, 3 * UNIT, MODE_MIRROR, MODE_MIRROR);
        sample_at(UNIT + UNIT / 2, 32'hFFFF_8000, MODE_SPARE, MODE_SPARE);
        sample_at(UNIT - 1, 32'h8000_0000, MODE_WRAP, MODE_WRAP);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF, MODE_WRAP, MODE_MIRROR);
        sample_at(32'h0001_7FFF, 32'h0000_5555, MODE_MIRROR, MODE_CLAMP);
    endtask

    initial
    begin : stimulus
        rst_n        <= 1'b0;
        push         <= 1'b0;
        req          <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_IMAGE_WIDTH;
        cfg_data     <= '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_image(9'd5, 9'd3);
        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            set_image(PHASE_W[p], PHASE_H[p]);
            calm = (p == CALM_PHASE);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                // hold the result side off so the block fills and stalls requests
                if (p == HOLD_PHASE && i == 10)
                    hold_request = 1'b1;
                random_item();
            end
            calm = 1'b0;
        end

        settle();
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> sim.f
sv/tans_pkg.sv
sv/tans_fifo.sv
sv/tans_front.sv
sv/tans_back.sv
sv/texture_address_nearest_sampler_top.sv
dv/tb_sampler_pkg.sv
dv/tb_top.sv
